// ===== src/eprm_pkg.sv =====
package eprm_pkg;

	// Field widths of the ranging channel.
	localparam int COUNT_WIDTH   = 32;
	localparam int OVERFLOW_BITS = 6;
	localparam int DIST_W        = 16;
	localparam int CMD_W         = 2;

	// Port widths: tdata is padded up to whole bytes.
	localparam int IN_TDATA_W  = ((COUNT_WIDTH + 7) / 8) * 8;
	localparam int OUT_FIELD_W = DIST_W + 2 + 1;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// The scale factor 17 is built as (1 << MUL_SHIFT) + 1.
	localparam int MUL_SHIFT = 4;
	localparam int DIVISOR   = 1000;
	localparam int DIV_W     = $clog2(DIVISOR);

	// Total pulse length and its scaled product.
	localparam int TOTAL_W = COUNT_WIDTH + OVERFLOW_BITS;
	localparam int PROD_W  = TOTAL_W + MUL_SHIFT + 1;
	localparam int CYC_W   = $clog2(PROD_W);

	// Configuration registers.
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FALLBACK = 1'b1;

	// Reset values.
	localparam logic [DIST_W-1:0] LIMIT_RST    = 16'd300;
	localparam logic [DIST_W-1:0] FALLBACK_RST = 16'd30;
	localparam logic [DIST_W-1:0] RANGE_RST    = 16'd30;

	typedef enum logic [CMD_W-1:0] {
		CMD_EDGE = 2'd0,
		CMD_OVF  = 2'd1,
		CMD_POLL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_MEAS = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_MUL,
		CS_DIV
	} calc_state_t;

	// Request from the channel control to the distance calculator.
	typedef struct packed {
		logic                     start;
		logic [OVERFLOW_BITS-1:0] ovf;
		logic [COUNT_WIDTH-1:0]   count;
	} calc_req_t;

	// Response from the distance calculator.
	typedef struct packed {
		logic              done;
		logic [DIST_W-1:0] quotient;
	} calc_rsp_t;

endpackage

// ===== src/eprm_range_calc.sv =====
module eprm_range_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  eprm_pkg::calc_req_t req,
	output eprm_pkg::calc_rsp_t rsp
);

	eprm_pkg::calc_state_t state_q, state_n;

	logic [eprm_pkg::TOTAL_W-1:0]       x_q;
	logic [eprm_pkg::OVERFLOW_BITS-1:0] o_q;
	logic                               borrow_q;
	logic [eprm_pkg::MUL_SHIFT-1:0]     dly_q;
	logic                               carry_q;
	logic [eprm_pkg::PROD_W-1:0]        p_q;
	logic [eprm_pkg::DIV_W-1:0]         rem_q;
	logic [eprm_pkg::DIST_W-1:0]        quot_q;
	logic [eprm_pkg::CYC_W-1:0]         cyc_q;
	logic                               done_q;

	logic mul_en, div_en, last_cyc;
	logic xbit, obit, tbit, borrow_n, pbit, carry_n;
	logic [1:0] bit_sum;
	logic [eprm_pkg::DIV_W:0] trial;
	logic                     ge;

	assign last_cyc = (cyc_q == eprm_pkg::CYC_W'(eprm_pkg::PROD_W - 1));

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			eprm_pkg::CS_IDLE: begin
				if (req.start) state_n = eprm_pkg::CS_MUL;
			end
			eprm_pkg::CS_MUL: begin
				if (last_cyc) state_n = eprm_pkg::CS_DIV;
			end
			eprm_pkg::CS_DIV: begin
				if (last_cyc) state_n = eprm_pkg::CS_IDLE;
			end
			default: state_n = eprm_pkg::CS_IDLE;
		endcase
	end

	// Step enables.
	always_comb begin
		mul_en = 1'b0;
		div_en = 1'b0;
		case (state_q)
			eprm_pkg::CS_MUL: mul_en = 1'b1;
			eprm_pkg::CS_DIV: div_en = 1'b1;
			default: begin
				mul_en = 1'b0;
				div_en = 1'b0;
			end
		endcase
	end

	// Serial subtract: total = {ovf, count} - ovf, one bit per cycle, LSB first.
	assign xbit     = x_q[0];
	assign obit     = o_q[0];
	assign tbit     = xbit ^ obit ^ borrow_q;
	assign borrow_n = (~xbit & obit) | (~(xbit ^ obit) & borrow_q);

	// Serial add: product = total + (total << MUL_SHIFT).
	assign bit_sum = {1'b0, tbit} + {1'b0, dly_q[eprm_pkg::MUL_SHIFT-1]} + {1'b0, carry_q};
	assign pbit    = bit_sum[0];
	assign carry_n = bit_sum[1];

	// Restoring division by the constant divisor, MSB first.
	assign trial = {rem_q, p_q[eprm_pkg::PROD_W-1]};
	assign ge    = (trial >= (eprm_pkg::DIV_W + 1)'(eprm_pkg::DIVISOR));

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eprm_pkg::CS_IDLE;
			cyc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= div_en && last_cyc;
			if ((mul_en || div_en) && !last_cyc) begin
				cyc_q <= cyc_q + 1'b1;
			end else begin
				cyc_q <= '0;
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (state_q == eprm_pkg::CS_IDLE && req.start) begin
			x_q      <= {req.ovf, req.count};
			o_q      <= req.ovf;
			borrow_q <= 1'b0;
			dly_q    <= '0;
			carry_q  <= 1'b0;
			rem_q    <= '0;
		end else if (mul_en) begin
			x_q      <= {1'b0, x_q[eprm_pkg::TOTAL_W-1:1]};
			o_q      <= {1'b0, o_q[eprm_pkg::OVERFLOW_BITS-1:1]};
			borrow_q <= borrow_n;
			dly_q    <= {dly_q[eprm_pkg::MUL_SHIFT-2:0], tbit};
			carry_q  <= carry_n;
			p_q      <= {pbit, p_q[eprm_pkg::PROD_W-1:1]};
		end else if (div_en) begin
			p_q    <= {p_q[eprm_pkg::PROD_W-2:0], 1'b0};
			rem_q  <= ge ? eprm_pkg::DIV_W'(trial - (eprm_pkg::DIV_W + 1)'(eprm_pkg::DIVISOR))
			             : trial[eprm_pkg::DIV_W-1:0];
			quot_q <= {quot_q[eprm_pkg::DIST_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

// ===== src/echo_pulse_range_meter_unit.sv =====
// Echo pulse range meter, one channel. Requests arrive on the s_ stream with the command
// in s_tuser (capture edge, timer overflow, distance poll) and the captured timer count in
// s_tdata; every request returns exactly one result on the m_ stream with the current
// distance, the measurement phase and a flag that marks a poll that consumed a finished
// measurement. A poll that consumes a measurement runs the bit-serial multiply by 17 and
// the bit-serial restoring division by 1000 in eprm_range_calc, each handling one product
// bit per cycle; other requests are answered directly. One request is in work at a time;
// a new request is taken only when the output register is empty or is read in that same
// cycle, so a stalled result also stalls the input. The distance limit and fallback
// registers are written through wr_en / wr_index / wr_data; the user must write them only
// while the unit is idle, as the unit itself does not enforce it.
module echo_pulse_range_meter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               wr_en,
	input  logic [eprm_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [eprm_pkg::DIST_W-1:0]        wr_data,
	// Request stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [eprm_pkg::IN_TDATA_W-1:0]    s_tdata,  // capture_count
	input  logic [eprm_pkg::CMD_W-1:0]         s_tuser,  // cmd
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [eprm_pkg::OUT_TDATA_W-1:0]   m_tdata   // distance, phase, new_reading
);

	eprm_pkg::top_state_t state_q, state_n;

	logic [eprm_pkg::DIST_W-1:0]        limit_q, fallback_q;
	logic                               started_q, done_q;
	logic [eprm_pkg::OVERFLOW_BITS-1:0] ovf_q;
	logic [eprm_pkg::COUNT_WIDTH-1:0]   count_q;
	logic [eprm_pkg::DIST_W-1:0]        range_q;

	logic                               out_valid_q;
	logic [eprm_pkg::DIST_W-1:0]        out_dist_q;
	eprm_pkg::phase_t                   out_phase_q;
	logic                               out_new_q;

	logic                               started_n, done_n;
	logic [eprm_pkg::OVERFLOW_BITS-1:0] ovf_n;
	logic [eprm_pkg::COUNT_WIDTH-1:0]   count_n;
	logic [eprm_pkg::DIST_W-1:0]        range_n, calc_range;
	logic                               fresh_calc;
	eprm_pkg::phase_t                   phase_n;
	eprm_pkg::cmd_t                     cmd;
	logic [eprm_pkg::COUNT_WIDTH-1:0]   cap;

	logic out_free, accept, emit_load, direct_load;

	eprm_pkg::calc_req_t calc_req;
	eprm_pkg::calc_rsp_t calc_rsp;

	assign cmd      = eprm_pkg::cmd_t'(s_tuser);
	assign cap      = s_tdata[eprm_pkg::COUNT_WIDTH-1:0];
	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Channel state after the current request.
	always_comb begin
		started_n  = started_q;
		done_n     = done_q;
		ovf_n      = ovf_q;
		count_n    = count_q;
		range_n    = range_q;
		fresh_calc = 1'b0;
		case (cmd)
			eprm_pkg::CMD_EDGE: begin
				if (!done_q) begin
					if (started_q) begin
						done_n  = 1'b1;
						count_n = cap;
					end else begin
						started_n = 1'b1;
						ovf_n     = '0;
						count_n   = '0;
					end
				end
			end
			eprm_pkg::CMD_OVF: begin
				if (!done_q && started_q) begin
					if (ovf_q == '1) begin
						done_n  = 1'b1;
						count_n = '1;
					end else begin
						ovf_n = ovf_q + 1'b1;
					end
				end
			end
			eprm_pkg::CMD_POLL: begin
				if (done_q) begin
					fresh_calc = 1'b1;
					started_n  = 1'b0;
					done_n     = 1'b0;
					ovf_n      = '0;
				end else if (range_q > limit_q) begin
					range_n = fallback_q;
				end
			end
			default: fresh_calc = 1'b0;
		endcase
	end

	// Phase reported with the result.
	always_comb begin
		if (done_n) begin
			phase_n = eprm_pkg::PH_DONE;
		end else if (started_n) begin
			phase_n = eprm_pkg::PH_MEAS;
		end else begin
			phase_n = eprm_pkg::PH_IDLE;
		end
	end

	// Limit rule on a freshly computed distance.
	assign calc_range = (calc_rsp.quotient > limit_q) ? fallback_q : calc_rsp.quotient;

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			eprm_pkg::ST_IDLE: begin
				if (accept && fresh_calc) state_n = eprm_pkg::ST_CALC;
			end
			eprm_pkg::ST_CALC: begin
				if (calc_rsp.done) state_n = eprm_pkg::ST_EMIT;
			end
			eprm_pkg::ST_EMIT: begin
				if (out_free) state_n = eprm_pkg::ST_IDLE;
			end
			default: state_n = eprm_pkg::ST_IDLE;
		endcase
	end

	// Handshake and load controls.
	always_comb begin
		s_tready  = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			eprm_pkg::ST_IDLE: s_tready  = out_free;
			eprm_pkg::ST_EMIT: emit_load = out_free;
			default: begin
				s_tready  = 1'b0;
				emit_load = 1'b0;
			end
		endcase
	end

	assign direct_load = accept && !fresh_calc;

	// Request to the distance calculator.
	assign calc_req.start = accept && fresh_calc;
	assign calc_req.ovf   = ovf_q;
	assign calc_req.count = count_q;

	eprm_range_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calc_req),
		.rsp    (calc_rsp)
	);

	// Configuration, channel state and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= eprm_pkg::ST_IDLE;
			limit_q     <= eprm_pkg::LIMIT_RST;
			fallback_q  <= eprm_pkg::FALLBACK_RST;
			started_q   <= 1'b0;
			done_q      <= 1'b0;
			ovf_q       <= '0;
			count_q     <= '0;
			range_q     <= eprm_pkg::RANGE_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (wr_en) begin
				case (wr_index)
					eprm_pkg::REG_LIMIT:    limit_q    <= wr_data;
					eprm_pkg::REG_FALLBACK: fallback_q <= wr_data;
					default: limit_q <= limit_q;
				endcase
			end
			if (accept) begin
				started_q <= started_n;
				done_q    <= done_n;
				ovf_q     <= ovf_n;
				count_q   <= count_n;
				range_q   <= range_n;
			end else if (state_q == eprm_pkg::ST_CALC && calc_rsp.done) begin
				range_q <= calc_range;
			end
			if (direct_load || emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (direct_load) begin
			out_dist_q  <= range_n;
			out_phase_q <= phase_n;
			out_new_q   <= 1'b0;
		end else if (emit_load) begin
			out_dist_q  <= range_q;
			out_phase_q <= eprm_pkg::PH_IDLE;
			out_new_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(eprm_pkg::OUT_TDATA_W - eprm_pkg::OUT_FIELD_W)'(0),
	                   out_new_q, out_phase_q, out_dist_q};

	// A finished measurement implies a started one.
	a_done_started: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> started_q)
		else $error("measurement done without start");

	// The calculator only finishes while the controller waits for it.
	a_calc_owned: assert property (@(posedge clk) disable iff (!arst_n)
		calc_rsp.done |-> state_q == eprm_pkg::ST_CALC)
		else $error("calculator result with no pending poll");

	// A consuming poll leaves the channel idle and clear.
	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		calc_req.start |=> !started_q && !done_q && ovf_q == '0)
		else $error("poll did not clear the channel");

	// A fresh reading always reports the idle phase.
	a_new_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_new_q |-> out_phase_q == eprm_pkg::PH_IDLE)
		else $error("new reading with a busy phase");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import eprm_pkg::*;

	// The command value that has no meaning; the unit must leave its state alone.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Result field positions in m_tdata.
	localparam int PHASE_LSB = DIST_W;
	localparam int FRESH_BIT = DIST_W + 2;

	// Round trip at 340 m/s gives 0.017 cm per timer tick.
	localparam logic [63:0] CM_PER_KTICK = 64'd17;
	localparam logic [63:0] TICK_SCALE   = 64'd1000;
	localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX = '1;
	localparam logic [OVERFLOW_BITS-1:0] OVF_MAX   = '1;

	localparam int CALC_CYCLES = 2 * PROD_W + 3;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_EVENTS  = 225;

	typedef struct {
		logic [CMD_W-1:0]       cmd;
		logic [COUNT_WIDTH-1:0] count;
	} echo_event_t;

	typedef struct {
		logic [DIST_W-1:0] distance;
		phase_t            phase;
		logic              fresh;
	} reading_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   wr_en = 1'b0;
	logic [REG_IDX_W-1:0]   wr_index = '0;
	logic [DIST_W-1:0]      wr_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	echo_event_t echo_events[$];
	reading_t    readings_due[$];
	echo_event_t next_event;
	reading_t    want;
	int          send_gap;
	int          ready_hold;
	int          mismatch_count;
	bit          idle_en;

	// Predicted channel state and register copies.
	logic                     echo_started;
	logic                     echo_done;
	logic [OVERFLOW_BITS-1:0] ovf_tally;
	logic [COUNT_WIDTH-1:0]   echo_count;
	logic [DIST_W-1:0]        range_cm;
	logic [DIST_W-1:0]        limit_cm;
	logic [DIST_W-1:0]        fallback_cm;

	echo_pulse_range_meter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Applies one request to the predicted channel and returns the reading it reports.
	function automatic reading_t range_meter_step(logic [CMD_W-1:0] cmd,
			logic [COUNT_WIDTH-1:0] cnt);
		logic [63:0] total;
		logic [63:0] quot;
		reading_t    r;
		r.fresh = 1'b0;
		case (cmd)
			CMD_EDGE: begin
				// An edge while a measurement waits for its poll is dropped.
				if (!echo_done) begin
					if (echo_started) begin
						echo_done  = 1'b1;
						echo_count = cnt;
					end else begin
						echo_started = 1'b1;
						ovf_tally    = '0;
						echo_count   = '0;
					end
				end
			end
			CMD_OVF: begin
				if (!echo_done && echo_started) begin
					if (ovf_tally == OVF_MAX) begin
						echo_done  = 1'b1;
						echo_count = COUNT_MAX;
					end else begin
						ovf_tally = ovf_tally + 1'b1;
					end
				end
			end
			CMD_POLL: begin
				if (echo_done) begin
					total = 64'(ovf_tally) * 64'(COUNT_MAX) + 64'(echo_count);
					quot = (total * CM_PER_KTICK) / TICK_SCALE;
					range_cm     = quot[DIST_W-1:0];
					echo_done    = 1'b0;
					echo_started = 1'b0;
					ovf_tally    = '0;
					r.fresh      = 1'b1;
				end
				// The clamp applies on every poll, fresh or not.
				if (range_cm > limit_cm)
					range_cm = fallback_cm;
			end
			default: begin
			end
		endcase
		r.distance = range_cm;
		if (echo_done)
			r.phase = PH_DONE;
		else if (echo_started)
			r.phase = PH_MEAS;
		else
			r.phase = PH_IDLE;
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_idle();
		int unsigned r;
		if (!idle_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] pick_count();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return COUNT_WIDTH'($urandom_range(0, 70000));
		if (r < 85)
			return COUNT_WIDTH'($urandom);
		if (r < 92)
			return '0;
		return COUNT_MAX;
	endfunction

	task automatic add_event(logic [CMD_W-1:0] cmd, logic [COUNT_WIDTH-1:0] cnt);
		echo_event_t e;
		e.cmd   = cmd;
		e.count = cnt;
		echo_events.push_back(e);
	endtask

	task automatic flag_mismatch(string what, logic [63:0] exp_val, logic [63:0] act_val);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what,
				exp_val, act_val);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_LIMIT)
			limit_cm = val;
		else
			fallback_cm = val;
	endtask

	task automatic wait_idle();
		while (echo_events.size() != 0 || s_tvalid || readings_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One echo measurement with random content, sometimes disturbed.
	task automatic add_measurement(ref int added);
		int n_ovf;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			n_ovf = $urandom_range(0, 3);
		else if (r < 88)
			n_ovf = $urandom_range(4, 59);
		else
			n_ovf = $urandom_range(60, 68);
		add_event(CMD_EDGE, COUNT_WIDTH'($urandom));
		added++;
		for (int i = 0; i < n_ovf; i++) begin
			add_event(CMD_OVF, COUNT_WIDTH'($urandom));
			added++;
			if ($urandom_range(0, 99) < 3) begin
				add_event(CMD_POLL, pick_count());
				added++;
			end
		end
		add_event(CMD_EDGE, pick_count());
		added++;
		// Requests that a finished measurement must ignore.
		if ($urandom_range(0, 9) == 0) begin
			add_event(logic'($urandom_range(0, 1)) ? CMD_EDGE : CMD_OVF, pick_count());
			added++;
		end
		if ($urandom_range(0, 9) != 0) begin
			add_event(CMD_POLL, COUNT_WIDTH'($urandom));
			added++;
		end
	endtask

	task automatic add_random_phase(int n_events);
		int added;
		added = 0;
		while (added < n_events) begin
			if ($urandom_range(0, 99) < 75) begin
				add_measurement(added);
			end else begin
				add_event(CMD_W'($urandom_range(0, 3)), COUNT_WIDTH'($urandom));
				added++;
			end
		end
	endtask

	// Request driver: accepted requests are predicted at the accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				readings_due.push_back(range_meter_step(s_tuser, s_tdata));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (echo_events.size() != 0) begin
					next_event = echo_events.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= next_event.cmd;
					s_tdata  <= IN_TDATA_W'(next_event.count);
					send_gap = pick_idle();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (readings_due.size() == 0) begin
					flag_mismatch("unexpected result", '0, 64'(m_tdata));
				end else begin
					want = readings_due.pop_front();
					if (m_tdata[DIST_W-1:0] !== want.distance)
						flag_mismatch("distance", 64'(want.distance),
							64'(m_tdata[DIST_W-1:0]));
					if (m_tdata[PHASE_LSB +: 2] !== want.phase)
						flag_mismatch("phase", 64'(want.phase),
							64'(m_tdata[PHASE_LSB +: 2]));
					if (m_tdata[FRESH_BIT] !== want.fresh)
						flag_mismatch("new_reading", 64'(want.fresh),
							64'(m_tdata[FRESH_BIT]));
					if (m_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
						flag_mismatch("tdata padding", '0,
							64'(m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
				end
			end
			if (ready_hold > 0) begin
				ready_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				ready_hold = pick_idle();
			end
		end
	end

	initial begin
		logic [DIST_W-1:0] lim;
		logic [DIST_W-1:0] fb;
		echo_started   = 1'b0;
		echo_done      = 1'b0;
		ovf_tally      = '0;
		echo_count     = '0;
		range_cm       = RANGE_RST;
		limit_cm       = LIMIT_RST;
		fallback_cm    = FALLBACK_RST;
		mismatch_count = 0;
		idle_en        = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass under the reset register values (limit 300, fallback 30).
		@(negedge clk);
		add_event(CMD_POLL, '0);           // poll with nothing measured
		add_event(CMD_UNUSED, COUNT_MAX);  // unused command
		add_event(CMD_OVF, '0);            // overflow while idle
		add_event(CMD_EDGE, COUNT_MAX);    // start; its count is not kept
		add_event(CMD_OVF, '0);
		add_event(CMD_EDGE, '0);           // one overflow, count zero
		add_event(CMD_EDGE, 32'd123);      // edge while done
		add_event(CMD_OVF, '0);            // overflow while done
		add_event(CMD_UNUSED, '0);
		add_event(CMD_POLL, '0);           // wrapped quotient, then clamped
		add_event(CMD_POLL, '0);
		add_event(CMD_EDGE, '0);
		add_event(CMD_EDGE, 32'd17647);    // just under the limit
		add_event(CMD_POLL, '0);
		add_event(CMD_EDGE, '0);
		add_event(CMD_EDGE, 32'd17706);    // just over the limit
		add_event(CMD_POLL, '0);
		add_event(CMD_EDGE, '0);
		add_event(CMD_POLL, COUNT_MAX);    // poll while measuring
		add_event(CMD_EDGE, COUNT_MAX);    // largest count with no overflow
		add_event(CMD_POLL, '0);
		add_event(CMD_EDGE, 32'hAAAA_AAAA);
		add_event(CMD_EDGE, 32'h5555_5555);
		add_event(CMD_POLL, '0);
		wait_idle();

		// Random phases, each under its own register setting.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					lim = '0;
					fb  = '0;
				end
				1: begin
					lim = '1;
					fb  = '1;
				end
				2: begin
					lim = '1;
					fb  = '0;
				end
				3: begin
					lim = '0;
					fb  = '1;
				end
				4: begin
					lim = DIST_W'($urandom_range(200, 1500));
					fb  = DIST_W'($urandom);
				end
				default: begin
					lim = DIST_W'($urandom);
					fb  = DIST_W'($urandom);
				end
			endcase
			write_reg(REG_LIMIT, lim);
			write_reg(REG_FALLBACK, fb);
			@(negedge clk);
			idle_en = (p != 3);
			add_random_phase(PHASE_EVENTS);
			wait_idle();
		end

		repeat (CALC_CYCLES + 10) @(posedge clk);
		if (mismatch_count == 0 && readings_due.size() == 0)
			$display("echo_pulse_range_meter_unit regression: pass");
		else
			$display("echo_pulse_range_meter_unit regression: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4000000;
		$display("echo_pulse_range_meter_unit regression: fail");
		$finish;
	end

endmodule
